[rtl/core/assert_macros.svh]
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/core/wth_pkg.sv]
package wth_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int MIN_LETTERS = 4;
	localparam int LETTER_W    = $clog2(MIN_LETTERS + 1);
	localparam int OUT_CNT_W   = 32;
	localparam int HASH_W      = 64;

	localparam logic [HASH_W-1:0]      HASH_MUL     = HASH_W'(147);
	localparam logic [7:0]             CHAR_LO      = 8'd32;
	localparam logic [7:0]             CHAR_HI      = 8'd126;
	localparam logic [7:0]             CASE_OFFSET  = 8'd32;
	localparam logic [7:0]             CHAR_NEWLINE = 8'h0A;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;

	typedef enum logic [1:0] {
		MODE_WHITE  = 2'd0,
		MODE_WORD   = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_BROKEN = 2'd3
	} scan_mode_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [HASH_W-1:0]      hash_t;

endpackage

[rtl/core/wth_in_if.sv]
interface wth_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source (output valid, output in_byte, output end_of_file, input ready);
	modport sink   (input valid, input in_byte, input end_of_file, output ready);

endinterface

[rtl/core/wth_out_if.sv]
interface wth_out_if;

	logic                              valid;
	logic                              ready;
	logic [wth_pkg::OUT_CNT_W-1:0]     char_total;
	logic [wth_pkg::OUT_CNT_W-1:0]     line_total;
	logic [wth_pkg::OUT_CNT_W-1:0]     word_total;
	logic                              word_done;
	logic [wth_pkg::HASH_W-1:0]        word_hash;

	modport source (
		output valid, output char_total, output line_total, output word_total,
		output word_done, output word_hash, input ready
	);
	modport sink (
		input valid, input char_total, input line_total, input word_total,
		input word_done, input word_hash, output ready
	);

endinterface

[rtl/core/word_tokenizer_hash.sv]
// Byte-stream tokenizer with a case-folded polynomial word hash.
// byte_chan (sink): one beat per text byte, or an end-of-file mark when
//   end_of_file is set (in_byte is then ignored).
// result_chan (source): one beat per input beat, in order, carrying the
//   saturating character, line and word totals, and word_done/word_hash
//   when that byte closed a valid word (word_hash is zero otherwise).
// Path: a byte taken is registered in the input stage; its result is
//   then registered in the result register and offered on result_chan.
// Throughput: one beat per cycle while result_chan is ready. Scanner
//   state and counters are computed combinationally between the input
//   stage and result register, the hash step one constant multiply and add.
// Reset: arst_n clears the scanner to white mode, zeroes all counters and the
//   running hashes, marks the start of a line and empties both stages.
// Stall: while result_chan is not ready a pending result holds; an empty
//   input stage still takes one more byte, then byte_chan.ready drops until
//   the result is taken.
`include "assert_macros.svh"

module word_tokenizer_hash (
	input  logic              clk,
	input  logic              arst_n,
	wth_in_if.sink            byte_chan,
	wth_out_if.source         result_chan
);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          eof_s1;

	wth_pkg::scan_mode_t           mode_q, mode_d;
	logic [wth_pkg::LETTER_W-1:0]  letters_q, letters_d;
	wth_pkg::hash_t                hash_run_q, hash_run_d;
	wth_pkg::hash_t                hash_let_q, hash_let_d;
	logic                          line_start_q, line_start_d;
	wth_pkg::count_t               chars_q, chars_d;
	wth_pkg::count_t               lines_q, lines_d;
	wth_pkg::count_t               words_q, words_d;

	logic                          out_valid_q;
	logic                          done_q;
	wth_pkg::hash_t                hash_out_q;

	logic                          advance;
	logic                          printable;
	logic [7:0]                    ch;
	logic [7:0]                    ch_up;
	logic                          is_letter;
	logic                          is_digit;
	logic                          done_c;
	wth_pkg::hash_t                hash_out_c;
	wth_pkg::hash_t                hash_step;

	assign advance         = !out_valid_q || result_chan.ready;
	assign byte_chan.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_chan.ready) begin
			valid_s1 <= byte_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_chan.ready && byte_chan.valid) begin
			byte_s1 <= byte_chan.in_byte;
			eof_s1  <= byte_chan.end_of_file;
		end
	end

	assign printable = !eof_s1 && byte_s1 >= wth_pkg::CHAR_LO && byte_s1 <= wth_pkg::CHAR_HI;
	assign ch        = printable ? byte_s1 : 8'd0;
	assign is_letter = ch inside {["A":"Z"], ["a":"z"]};
	assign is_digit  = ch inside {["0":"9"]};
	assign ch_up     = (ch inside {["a":"z"]}) ? ch - wth_pkg::CASE_OFFSET : ch;
	assign hash_step = hash_run_q * wth_pkg::HASH_MUL
		+ wth_pkg::HASH_W'(is_letter ? ch_up : ch);

	// next state
	always_comb begin
		mode_d       = mode_q;
		letters_d    = letters_q;
		hash_run_d   = hash_run_q;
		hash_let_d   = hash_let_q;
		line_start_d = line_start_q;
		chars_d      = chars_q;
		lines_d      = lines_q;
		words_d      = words_q;

		if (!eof_s1) begin
			if (line_start_q && lines_q != wth_pkg::COUNT_MAX) begin
				lines_d = lines_q + 1'b1;
			end
			line_start_d = (byte_s1 == wth_pkg::CHAR_NEWLINE);
		end else begin
			line_start_d = 1'b1;
		end

		if (printable && chars_q != wth_pkg::COUNT_MAX) begin
			chars_d = chars_q + 1'b1;
		end

		if (is_letter) begin
			case (mode_q)
				wth_pkg::MODE_WHITE: begin
					hash_run_d = wth_pkg::HASH_W'(ch_up);
					hash_let_d = wth_pkg::HASH_W'(ch_up);
					letters_d  = wth_pkg::LETTER_W'(1);
					mode_d     = wth_pkg::MODE_WORD;
				end
				wth_pkg::MODE_WORD, wth_pkg::MODE_BROKEN: begin
					hash_run_d = hash_step;
					hash_let_d = hash_step;
					if (mode_q == wth_pkg::MODE_WORD
						&& letters_q < wth_pkg::LETTER_W'(wth_pkg::MIN_LETTERS)) begin
						letters_d = letters_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (is_digit) begin
			case (mode_q)
				wth_pkg::MODE_WORD, wth_pkg::MODE_BROKEN: begin
					hash_run_d = hash_step;
					if (mode_q == wth_pkg::MODE_WORD
						&& letters_q < wth_pkg::LETTER_W'(wth_pkg::MIN_LETTERS)) begin
						mode_d = wth_pkg::MODE_BROKEN;
					end
				end
				default: begin
					mode_d = wth_pkg::MODE_NUMBER;
				end
			endcase
		end else begin
			mode_d = wth_pkg::MODE_WHITE;
			if (done_c && words_q != wth_pkg::COUNT_MAX) begin
				words_d = words_q + 1'b1;
			end
		end
	end

	// outputs
	always_comb begin
		done_c     = !is_letter && !is_digit && mode_q == wth_pkg::MODE_WORD
			&& letters_q >= wth_pkg::LETTER_W'(wth_pkg::MIN_LETTERS);
		hash_out_c = done_c ? hash_let_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= wth_pkg::MODE_WHITE;
			letters_q    <= '0;
			hash_run_q   <= '0;
			hash_let_q   <= '0;
			line_start_q <= 1'b1;
			chars_q      <= '0;
			lines_q      <= '0;
			words_q      <= '0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				mode_q       <= mode_d;
				letters_q    <= letters_d;
				hash_run_q   <= hash_run_d;
				hash_let_q   <= hash_let_d;
				line_start_q <= line_start_d;
				chars_q      <= chars_d;
				lines_q      <= lines_d;
				words_q      <= words_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			done_q     <= done_c;
			hash_out_q <= hash_out_c;
		end
	end

	assign result_chan.valid      = out_valid_q;
	assign result_chan.char_total = wth_pkg::OUT_CNT_W'(chars_q);
	assign result_chan.line_total = wth_pkg::OUT_CNT_W'(lines_q);
	assign result_chan.word_total = wth_pkg::OUT_CNT_W'(words_q);
	assign result_chan.word_done  = done_q;
	assign result_chan.word_hash  = hash_out_q;

	`ASSERT_CLK(a_hash_zero_idle, clk, arst_n,
		(out_valid_q && !done_q) |-> (hash_out_q == '0), "hash set without a word")
	`ASSERT_CLK(a_words_hold, clk, arst_n,
		(advance && valid_s1 && !done_c) |=> $stable(words_q), "word count moved without a word")
	`ASSERT_CLK(a_result_follows, clk, arst_n,
		(advance && valid_s1) |=> out_valid_q, "accepted byte produced no result")
	`ASSERT_NEVER(a_letters_bound, clk, arst_n,
		letters_q > wth_pkg::LETTER_W'(wth_pkg::MIN_LETTERS), "leading letter count overran")

endmodule

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 4000;

	typedef struct packed {
		logic [wth_pkg::OUT_CNT_W-1:0] chars;
		logic [wth_pkg::OUT_CNT_W-1:0] lines;
		logic [wth_pkg::OUT_CNT_W-1:0] words;
		logic                          done;
		wth_pkg::hash_t                hash;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wth_in_if  in_if ();
	wth_out_if out_if ();

	word_tokenizer_hash dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_chan   (in_if),
		.result_chan (out_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	wth_pkg::scan_mode_t scan        = wth_pkg::MODE_WHITE;
	logic [2:0]          lead        = '0;
	wth_pkg::hash_t      hash_run    = '0;
	wth_pkg::hash_t      hash_letter = '0;
	logic                line_start  = 1'b1;
	wth_pkg::count_t     chars_seen  = '0;
	wth_pkg::count_t     lines_seen  = '0;
	wth_pkg::count_t     words_seen  = '0;

	tally_t           totals_due[$];
	int unsigned      mismatches = 0;
	int unsigned      beats_sent = 0;
	int unsigned      snd_idle_pct = 0;
	int unsigned      rcv_idle_pct = 0;
	int unsigned      hold_req_len = 0;
	int unsigned      hold_req_id = 0;
	int unsigned      hold_taken_id = 0;
	int unsigned      hold_left = 0;
	int unsigned      quiet_cycles = 0;

	function automatic wth_pkg::count_t bump(wth_pkg::count_t v);
		return (v == wth_pkg::COUNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic tally_t tokenize_beat(logic [7:0] b, logic eof);
		tally_t         r;
		logic [7:0]     c;
		wth_pkg::hash_t up;
		r = '0;
		if (!eof) begin
			if (line_start)
				lines_seen = bump(lines_seen);
			line_start = (b == wth_pkg::CHAR_NEWLINE);
		end else begin
			line_start = 1'b1;
		end
		c = b;
		if (eof || b < wth_pkg::CHAR_LO || b > wth_pkg::CHAR_HI)
			c = 8'h00;
		else
			chars_seen = bump(chars_seen);
		if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
			up = wth_pkg::hash_t'((c >= "a") ? c - wth_pkg::CASE_OFFSET : c);
			case (scan)
			wth_pkg::MODE_WHITE: begin
				hash_run = up;
				hash_letter = up;
				lead = 3'd1;
				scan = wth_pkg::MODE_WORD;
			end
			wth_pkg::MODE_WORD, wth_pkg::MODE_BROKEN: begin
				hash_run = hash_run * wth_pkg::HASH_MUL + up;
				hash_letter = hash_run;
				if (scan == wth_pkg::MODE_WORD && lead < wth_pkg::MIN_LETTERS)
					lead = lead + 3'd1;
			end
			default: ;
			endcase
		end else if (c >= "0" && c <= "9") begin
			if (scan == wth_pkg::MODE_WORD || scan == wth_pkg::MODE_BROKEN) begin
				hash_run = hash_run * wth_pkg::HASH_MUL + wth_pkg::hash_t'(c);
				if (scan == wth_pkg::MODE_WORD && lead < wth_pkg::MIN_LETTERS)
					scan = wth_pkg::MODE_BROKEN;
			end else begin
				scan = wth_pkg::MODE_NUMBER;
			end
		end else begin
			if (scan == wth_pkg::MODE_WORD && lead >= wth_pkg::MIN_LETTERS) begin
				r.done = 1'b1;
				r.hash = hash_letter;
				words_seen = bump(words_seen);
			end
			scan = wth_pkg::MODE_WHITE;
		end
		r.chars = chars_seen[wth_pkg::OUT_CNT_W-1:0];
		r.lines = lines_seen[wth_pkg::OUT_CNT_W-1:0];
		r.words = words_seen[wth_pkg::OUT_CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_if.valid && in_if.ready)
			totals_due.insert(totals_due.size(),
				tokenize_beat(in_if.in_byte, in_if.end_of_file));
	end

	always @(posedge clk) begin : check_results
		tally_t got;
		tally_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = '{out_if.char_total, out_if.line_total, out_if.word_total,
				out_if.word_done, out_if.word_hash};
			if (totals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: chars %0d lines %0d words %0d done %0b hash %h",
						got.chars, got.lines, got.words, got.done, got.hash);
			end else begin
				want = totals_due.pop_front();
				if (got.chars !== want.chars || got.lines !== want.lines ||
						got.words !== want.words || got.done !== want.done ||
						got.hash !== want.hash) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch want: chars %0d lines %0d words %0d done %0b hash %h",
							want.chars, want.lines, want.words, want.done, want.hash);
						$display("         got:  chars %0d lines %0d words %0d done %0b hash %h",
							got.chars, got.lines, got.words, got.done, got.hash);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req_id != hold_taken_id) begin
			hold_taken_id <= hold_req_id;
			hold_left <= hold_req_len;
			out_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	task automatic send_beat(logic [7:0] b, logic eof);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.in_byte <= b;
		in_if.end_of_file <= eof;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (totals_due.size() != 0);
	endtask

	// valid word, short broken word, number swallowing letters, trailing digits, eof close
	task automatic test_directed();
		send_text("Abcd xyz9\n12ab~wOrd42");
		send_beat(8'hA5, 1'b1);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h7F, 1'b0);
		send_beat(8'h1F, 1'b0);
	endtask

	task automatic test_random_text(int unsigned n_beats);
		int unsigned stop;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  ch;
		stop = beats_sent + n_beats;
		while (beats_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				send_beat(8'($urandom), ($urandom_range(7) == 0));
			end else begin
				len = $urandom_range(1, 9);
				for (int k = 0; k < len; k++) begin
					if ((k == 0 && pick < 20) || (k > 0 && $urandom_range(4) == 0))
						ch = "0" + 8'($urandom_range(9));
					else
						ch = 8'($urandom_range(25)) + ($urandom_range(1) ? "A" : "a");
					send_beat(ch, 1'b0);
				end
				case ($urandom_range(7))
				0: send_beat(8'($urandom), 1'b1);
				1: send_beat(wth_pkg::CHAR_NEWLINE, 1'b0);
				2: send_beat(8'($urandom_range(31)), 1'b0);
				3: send_beat(8'($urandom_range(255, 127)), 1'b0);
				4: send_beat("!" + 8'($urandom_range(14)), 1'b0);
				5: send_beat(wth_pkg::CHAR_HI, 1'b0);
				default: send_beat(wth_pkg::CHAR_LO, 1'b0);
				endcase
			end
		end
	endtask

	// hold the result side long enough to back up the input
	task automatic test_output_stall();
		logic [7:0] ch;
		hold_req_len <= 200;
		hold_req_id <= hold_req_id + 1;
		for (int k = 0; k < 40; k++) begin
			ch = (k % 6 == 5) ? wth_pkg::CHAR_LO : "a" + 8'($urandom_range(25));
			send_beat(ch, 1'b0);
		end
	endtask

	task automatic test_pause_until_drained();
		test_random_text(20);
		wait_drained();
		test_random_text(20);
	endtask

	initial begin
		in_if.valid <= 1'b0;
		in_if.in_byte <= 8'h00;
		in_if.end_of_file <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 10;
		rcv_idle_pct = 69;
		test_directed();
		test_random_text(520);
		test_output_stall();

		snd_idle_pct = 69;
		rcv_idle_pct = 10;
		test_random_text(520);
		test_pause_until_drained();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		test_random_text(520);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && totals_due.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
